@@ sv/ccts_pkg.sv @@
// shared constants, types and helpers for the chroma colour temperature shift
`timescale 1ns / 1ps
`default_nettype none

package ccts_pkg;

   // field widths
   localparam int LumaWidth   = 8;
   localparam int ChromaWidth = 8;
   localparam int GainWidth   = 16;
   localparam int CsrIdxWidth = 2;

   // scaled luma: 7 * (m - 16) in reduced range needs 11 bits
   localparam int MultWidth   = 11;
   localparam int ProdWidth   = GainWidth + MultWidth;
   localparam int QuotWidth   = 8;
   localparam int SumWidth    = 10;

   // register indexes of the configuration port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_U_GAIN        = 2'd0,
      CSR_V_GAIN        = 2'd1,
      CSR_REDUCED_RANGE = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   // reduced range offset and chroma limits
   localparam logic [LumaWidth-1:0]   LumaOffset    = 8'd16;
   localparam logic [ChromaWidth-1:0] ChromaRedLo   = 8'd16;
   localparam logic [ChromaWidth-1:0] ChromaRedHi   = 8'd239;
   localparam logic [ChromaWidth-1:0] ChromaFullLo  = 8'd0;
   localparam logic [ChromaWidth-1:0] ChromaFullHi  = 8'd255;

   // ceil(2^23 / 219), exact floor(y / 219) for y below 2^15
   localparam logic [15:0] Recip219      = 16'd38305;
   localparam int          Recip219Shift = 23;

   // clamp a signed sum into the legal chroma range
   function automatic logic [ChromaWidth-1:0] clamp_chroma(
      input logic signed [SumWidth-1:0] sum,
      input logic                       reduced
   );
      logic signed [SumWidth-1:0] lo;
      logic signed [SumWidth-1:0] hi;
      logic [ChromaWidth-1:0]     res;
      lo = reduced ? $signed({2'b00, ChromaRedLo}) : $signed({2'b00, ChromaFullLo});
      hi = reduced ? $signed({2'b00, ChromaRedHi}) : $signed({2'b00, ChromaFullHi});
      if (sum < lo) begin
         res = lo[ChromaWidth-1:0];
      end else if (sum > hi) begin
         res = hi[ChromaWidth-1:0];
      end else begin
         res = sum[ChromaWidth-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ sv/chroma_color_temperature_shift.sv @@
// top level of the chroma colour temperature shift pipeline
`timescale 1ns / 1ps
`default_nettype none

// Chroma colour temperature shift for 4:2:0 chroma sites. One word is taken
// on every clock (busy never rises) and its result appears on the rsp_ ports
// for one cycle, marked by rsp_valid, after the stage 0, 1 and 2 registers.
// The pipeline has three registered stages: input capture, luma maximum and
// gain multiply, then constant division, chroma add and clamp. The receiver
// cannot stall, so results must be taken as they come. Gains and range are
// written through the csr_ port, which is always ready; write it only while
// no word is in flight.
module chroma_color_temperature_shift (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input words
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ccts_pkg::LumaWidth-1:0]    req_luma_top_left,
   input  wire logic [ccts_pkg::LumaWidth-1:0]    req_luma_top_right,
   input  wire logic [ccts_pkg::LumaWidth-1:0]    req_luma_bottom_left,
   input  wire logic [ccts_pkg::LumaWidth-1:0]    req_luma_bottom_right,
   input  wire logic [ccts_pkg::ChromaWidth-1:0]  req_chroma_u_in,
   input  wire logic [ccts_pkg::ChromaWidth-1:0]  req_chroma_v_in,
   // result words
   output logic                                   rsp_valid,
   output logic [ccts_pkg::ChromaWidth-1:0]       rsp_chroma_u_out,
   output logic [ccts_pkg::ChromaWidth-1:0]       rsp_chroma_v_out,
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ccts_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [ccts_pkg::GainWidth-1:0]    csr_data
);
   import ccts_pkg::*;

   // configuration registers
   logic signed [GainWidth-1:0] u_gain_ff;
   logic signed [GainWidth-1:0] v_gain_ff;
   logic                        reduced_ff;

   // stage 0: captured input word
   logic                   v0_ff;
   logic [LumaWidth-1:0]   tl0_ff, tr0_ff, bl0_ff, br0_ff;
   logic [ChromaWidth-1:0] cu0_ff, cv0_ff;

   // stage 1: gain magnitude times scaled luma
   logic                   v1_ff;
   logic                   red1_ff;
   logic [ProdWidth-1:0]   prod_u1_ff, prod_v1_ff;
   logic [ProdWidth-1:0]   prod_u1_in, prod_v1_in;
   logic                   neg_u1_ff, neg_v1_ff;
   logic [ChromaWidth-1:0] cu1_ff, cv1_ff;

   // stage 2: result register
   logic                   v2_ff;
   logic                   red2_ff;
   logic [ChromaWidth-1:0] cu2_ff, cv2_ff;
   logic [ChromaWidth-1:0] cu2_in, cv2_in;

   // stage 1 logic
   logic [LumaWidth-1:0]  max_top, max_bot, max_all, m_adj;
   logic [MultWidth-1:0]  mult;
   logic [GainWidth-1:0]  mag_u, mag_v;

   // stage 2 logic
   logic [14:0]               xu, xv, yu, yv;
   logic [15:0]               sum_fu, sum_fv;
   logic [30:0]               rec_u, rec_v;
   logic [QuotWidth-1:0]      qu, qv;
   logic signed [SumWidth-1:0] sh_u, sh_v, sum_u, sum_v;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         u_gain_ff  <= '0;
         v_gain_ff  <= '0;
         reduced_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_U_GAIN:        u_gain_ff  <= csr_data;
            CSR_V_GAIN:        v_gain_ff  <= csr_data;
            CSR_REDUCED_RANGE: reduced_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      tl0_ff <= req_luma_top_left;
      tr0_ff <= req_luma_top_right;
      bl0_ff <= req_luma_bottom_left;
      br0_ff <= req_luma_bottom_right;
      cu0_ff <= req_chroma_u_in;
      cv0_ff <= req_chroma_v_in;
   end

   // largest luma, range offset, scaling and gain multiply
   always_comb begin
      max_top = (tr0_ff > tl0_ff) ? tr0_ff : tl0_ff;
      max_bot = (br0_ff > bl0_ff) ? br0_ff : bl0_ff;
      max_all = (max_bot > max_top) ? max_bot : max_top;
      if (reduced_ff) begin
         m_adj = (max_all >= LumaOffset) ? max_all - LumaOffset : '0;
         // 224 / (256 * 256 * 219) reduces to 7 / (2048 * 219)
         mult  = {m_adj, 3'b000} - {3'b000, m_adj};
      end else begin
         m_adj = max_all;
         mult  = {3'b000, m_adj};
      end
      mag_u      = u_gain_ff[GainWidth-1] ? (~u_gain_ff + 1'b1) : u_gain_ff;
      mag_v      = v_gain_ff[GainWidth-1] ? (~v_gain_ff + 1'b1) : v_gain_ff;
      prod_u1_in = mag_u * mult;
      prod_v1_in = mag_v * mult;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      red1_ff    <= reduced_ff;
      prod_u1_ff <= prod_u1_in;
      prod_v1_ff <= prod_v1_in;
      neg_u1_ff  <= u_gain_ff[GainWidth-1];
      neg_v1_ff  <= v_gain_ff[GainWidth-1];
      cu1_ff     <= cu0_ff;
      cv1_ff     <= cv0_ff;
   end

   // constant division, sign, chroma add and clamp
   always_comb begin
      // full range: floor(p / 256 / 255)
      xu     = prod_u1_ff[22:8];
      xv     = prod_v1_ff[22:8];
      sum_fu = {1'b0, xu} + {9'd0, xu[14:8]} + 16'd1;
      sum_fv = {1'b0, xv} + {9'd0, xv[14:8]} + 16'd1;
      // reduced range: floor(p / 2048 / 219)
      yu     = prod_u1_ff[25:11];
      yv     = prod_v1_ff[25:11];
      rec_u  = yu * Recip219;
      rec_v  = yv * Recip219;
      if (red1_ff) begin
         qu = rec_u[Recip219Shift +: QuotWidth];
         qv = rec_v[Recip219Shift +: QuotWidth];
      end else begin
         qu = sum_fu[15:8];
         qv = sum_fv[15:8];
      end
      // truncation toward zero: negate the magnitude quotient
      sh_u   = neg_u1_ff ? -$signed({2'b00, qu}) : $signed({2'b00, qu});
      sh_v   = neg_v1_ff ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
      sum_u  = $signed({2'b00, cu1_ff}) + sh_u;
      sum_v  = $signed({2'b00, cv1_ff}) + sh_v;
      cu2_in = clamp_chroma(sum_u, red1_ff);
      cv2_in = clamp_chroma(sum_v, red1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      red2_ff <= red1_ff;
      cu2_ff  <= cu2_in;
      cv2_ff  <= cv2_in;
   end

   assign rsp_valid        = v2_ff;
   assign rsp_chroma_u_out = cu2_ff;
   assign rsp_chroma_v_out = cv2_ff;

   // every accepted word reaches the result port through the stage 1 and 2 registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      v0_ff |=> ##1 rsp_valid)
      else $error("accepted word did not reach the result port");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v1_ff))
      else $error("result strobe without a word in the pipeline");

   a_reduced_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && red2_ff) |->
         (rsp_chroma_u_out >= ChromaRedLo && rsp_chroma_u_out <= ChromaRedHi &&
          rsp_chroma_v_out >= ChromaRedLo && rsp_chroma_v_out <= ChromaRedHi))
      else $error("reduced range chroma outside 16..239");

endmodule

`default_nettype wire

@@ sim/tb_chroma_color_temperature_shift.sv @@
// self-checking testbench for the chroma colour temperature shift block
`timescale 1ns / 1ps

module tb_chroma_color_temperature_shift;
   import ccts_pkg::*;

   // one chroma site as sent on the req_ ports
   typedef struct packed {
      logic [LumaWidth-1:0]   top_left;
      logic [LumaWidth-1:0]   top_right;
      logic [LumaWidth-1:0]   bottom_left;
      logic [LumaWidth-1:0]   bottom_right;
      logic [ChromaWidth-1:0] chroma_u;
      logic [ChromaWidth-1:0] chroma_v;
   } chroma_site_type;

   // one shifted chroma pair as seen on the rsp_ ports
   typedef struct packed {
      logic [ChromaWidth-1:0] chroma_u;
      logic [ChromaWidth-1:0] chroma_v;
   } chroma_pair_type;

   localparam longint FullDivisor    = 256 * 255;
   localparam longint ReducedDivisor = 256 * 256 * 219;
   localparam longint ReducedScale   = 224;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [LumaWidth-1:0]   req_luma_top_left = '0;
   logic [LumaWidth-1:0]   req_luma_top_right = '0;
   logic [LumaWidth-1:0]   req_luma_bottom_left = '0;
   logic [LumaWidth-1:0]   req_luma_bottom_right = '0;
   logic [ChromaWidth-1:0] req_chroma_u_in = '0;
   logic [ChromaWidth-1:0] req_chroma_v_in = '0;
   logic                   rsp_valid;
   logic [ChromaWidth-1:0] rsp_chroma_u_out;
   logic [ChromaWidth-1:0] rsp_chroma_v_out;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_U_GAIN;
   logic [GainWidth-1:0]   csr_data = '0;

   // shadow copy of the block's registers
   logic signed [GainWidth-1:0] gain_u = '0;
   logic signed [GainWidth-1:0] gain_v = '0;
   logic                        range_reduced = 1'b0;

   chroma_pair_type expected_chroma[$];
   int              fault_count = 0;

   chroma_color_temperature_shift u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_luma_top_left     (req_luma_top_left),
      .req_luma_top_right    (req_luma_top_right),
      .req_luma_bottom_left  (req_luma_bottom_left),
      .req_luma_bottom_right (req_luma_bottom_right),
      .req_chroma_u_in       (req_chroma_u_in),
      .req_chroma_v_in       (req_chroma_v_in),
      .rsp_valid             (rsp_valid),
      .rsp_chroma_u_out      (rsp_chroma_u_out),
      .rsp_chroma_v_out      (rsp_chroma_v_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run time guard
   initial begin
      #5_000_000;
      $display("tb_chroma_color_temperature_shift: done, errors");
      $finish;
   end

   // shift proportional to the peak luma, truncated toward zero
   function automatic int luma_shift(input logic signed [GainWidth-1:0] gain,
                                     input int peak, input logic reduced);
      longint scaled;
      if (reduced) begin
         scaled = longint'(gain) * ReducedScale * peak;
         return int'(scaled / ReducedDivisor);
      end
      scaled = longint'(gain) * peak;
      return int'(scaled / FullDivisor);
   endfunction

   // clamp into the legal chroma range of the current mode
   function automatic logic [ChromaWidth-1:0] limit_chroma(input int sum,
                                                           input logic reduced);
      int lo;
      int hi;
      lo = reduced ? 16 : 0;
      hi = reduced ? 239 : 255;
      if (sum < lo) sum = lo;
      if (sum > hi) sum = hi;
      return ChromaWidth'(sum);
   endfunction

   // expected pair for one site under the shadow registers
   function automatic chroma_pair_type shifted_chroma(input chroma_site_type site);
      int              peak;
      chroma_pair_type pair;
      peak = site.top_left;
      if (site.top_right > peak) peak = site.top_right;
      if (site.bottom_left > peak) peak = site.bottom_left;
      if (site.bottom_right > peak) peak = site.bottom_right;
      if (range_reduced) peak = (peak > 16) ? peak - 16 : 0;
      pair.chroma_u = limit_chroma(int'(site.chroma_u) + luma_shift(gain_u, peak, range_reduced),
                                   range_reduced);
      pair.chroma_v = limit_chroma(int'(site.chroma_v) + luma_shift(gain_v, peak, range_reduced),
                                   range_reduced);
      return pair;
   endfunction

   function automatic chroma_site_type make_site(input int tl, input int tr, input int bl,
                                                 input int br, input int u, input int v);
      chroma_site_type site;
      site = {8'(tl), 8'(tr), 8'(bl), 8'(br), 8'(u), 8'(v)};
      return site;
   endfunction

   // random site, biased toward the luma and chroma corners
   function automatic chroma_site_type random_site();
      chroma_site_type site;
      int              luma_mode;
      site = 48'({$urandom, $urandom});
      luma_mode = $urandom_range(0, 7);
      if (luma_mode == 6) begin
         site.top_left     = LumaWidth'($urandom_range(0, 20));
         site.top_right    = LumaWidth'($urandom_range(0, 20));
         site.bottom_left  = LumaWidth'($urandom_range(0, 20));
         site.bottom_right = LumaWidth'($urandom_range(0, 20));
      end else if (luma_mode == 7) begin
         site.top_left = LumaWidth'($urandom_range(230, 255));
      end
      if ($urandom_range(0, 5) == 0) site.chroma_u = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      if ($urandom_range(0, 5) == 0) site.chroma_v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      return site;
   endfunction

   function automatic logic [GainWidth-1:0] random_gain(input bit beyond);
      if (beyond) return GainWidth'($urandom);
      return GainWidth'(int'($urandom_range(0, 51200)) - 25600);
   endfunction

   // send one word and log its expected result once it is taken
   task automatic send_site(input chroma_site_type site);
      start                 <= 1'b1;
      req_luma_top_left     <= site.top_left;
      req_luma_top_right    <= site.top_right;
      req_luma_bottom_left  <= site.bottom_left;
      req_luma_bottom_right <= site.bottom_right;
      req_chroma_u_in       <= site.chroma_u;
      req_chroma_v_in       <= site.chroma_v;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_chroma.push_back(shifted_chroma(site));
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // drain the pipeline before touching the registers
   task automatic settle();
      start <= 1'b0;
      while (expected_chroma.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, valid left high for back to back writes
   task automatic write_reg(input csr_index_type idx, input logic [GainWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_U_GAIN:        gain_u = data;
         CSR_V_GAIN:        gain_v = data;
         CSR_REDUCED_RANGE: range_reduced = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [GainWidth-1:0] u_gain,
                                 input logic [GainWidth-1:0] v_gain, input logic reduced);
      settle();
      write_reg(CSR_U_GAIN, u_gain);
      write_reg(CSR_V_GAIN, v_gain);
      write_reg(CSR_REDUCED_RANGE, {{(GainWidth-1){1'b0}}, reduced});
      csr_valid <= 1'b0;
   endtask

   // registers at reset: zero gains, full range, chroma passes through
   task automatic test_reset_defaults();
      send_site(make_site(0, 0, 0, 0, 0, 255));
      send_site(make_site(255, 255, 255, 255, 255, 0));
      send_site(make_site(128, 64, 32, 16, 128, 128));
   endtask

   // full range at the gain limits, peak luma in each corner
   task automatic test_full_range();
      apply_settings(16'sd25600, -16'sd25600, 1'b0);
      send_site(make_site(255, 0, 0, 0, 0, 255));
      send_site(make_site(0, 255, 0, 0, 128, 128));
      send_site(make_site(0, 0, 255, 0, 255, 0));
      send_site(make_site(0, 0, 0, 255, 200, 50));
      send_site(make_site(0, 0, 0, 0, 77, 77));
      send_site(make_site(100, 50, 25, 1, 128, 128));
   endtask

   // reduced range: dark luma, luma above 235, chroma clamped with no shift
   task automatic test_reduced_range();
      apply_settings(-16'sd25600, 16'sd25600, 1'b1);
      send_site(make_site(0, 5, 10, 15, 0, 255));
      send_site(make_site(16, 16, 16, 16, 15, 240));
      send_site(make_site(17, 0, 0, 0, 16, 239));
      send_site(make_site(235, 0, 0, 0, 128, 128));
      send_site(make_site(0, 0, 0, 255, 128, 128));
      send_site(make_site(255, 255, 255, 255, 239, 16));
      send_site(make_site(240, 100, 100, 100, 60, 200));
   endtask

   // gains past the nominal limits, used as full 16 bit values
   task automatic test_gain_beyond_range();
      apply_settings(16'h8000, 16'h7fff, 1'b0);
      send_site(make_site(255, 255, 255, 255, 255, 0));
      send_site(make_site(255, 255, 255, 255, 128, 128));
      apply_settings(16'h7fff, 16'h8000, 1'b1);
      send_site(make_site(255, 255, 255, 255, 128, 128));
      send_site(make_site(255, 255, 255, 255, 16, 239));
   endtask

   // spare index ignored, range flag takes bit 0 only
   task automatic test_unused_register();
      apply_settings(16'sd1000, -16'sd1000, 1'b1);
      settle();
      write_reg(CSR_UNUSED, 16'hffff);
      write_reg(CSR_REDUCED_RANGE, 16'hfffe);
      csr_valid <= 1'b0;
      send_site(make_site(255, 40, 40, 40, 250, 3));
      send_site(make_site(10, 200, 40, 90, 128, 128));
   endtask

   // random sites under one setting, idling in bursts when allowed
   task automatic test_random_stream(input int count, input logic [GainWidth-1:0] u_gain,
                                     input logic [GainWidth-1:0] v_gain, input logic reduced,
                                     input bit idling);
      int idle_odds;
      apply_settings(u_gain, v_gain, reduced);
      idle_odds = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) idle_odds = idling ? $urandom_range(0, 3) : 0;
         send_site(random_site());
         if (idle_odds != 0 && $urandom_range(1, 6 - idle_odds) == 1)
            hold_off($urandom_range(1, 5));
      end
   endtask

   // compare each result word with the oldest expectation
   always @(posedge clock) begin : check_results
      chroma_pair_type want;
      if (!reset && rsp_valid) begin
         if (expected_chroma.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected result u=%0d v=%0d", rsp_chroma_u_out, rsp_chroma_v_out);
            fault_count++;
         end else begin
            want = expected_chroma.pop_front();
            if (rsp_chroma_u_out !== want.chroma_u || rsp_chroma_v_out !== want.chroma_v) begin
               if (fault_count < 10)
                  $display("mismatch: expected u=%0d v=%0d, got u=%0d v=%0d",
                           want.chroma_u, want.chroma_v, rsp_chroma_u_out, rsp_chroma_v_out);
               fault_count++;
            end
         end
      end
   end

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_full_range();
      test_reduced_range();
      test_gain_beyond_range();
      test_unused_register();
      test_random_stream(150, random_gain(0), random_gain(0), 1'b0, 1'b1);
      test_random_stream(150, random_gain(0), random_gain(0), 1'b1, 1'b1);
      test_random_stream(120, 16'sd25600, -16'sd25600, 1'b0, 1'b1);
      test_random_stream(120, -16'sd25600, 16'sd25600, 1'b1, 1'b1);
      test_random_stream(150, random_gain(1), random_gain(1), 1'b0, 1'b1);
      test_random_stream(150, random_gain(1), random_gain(1), 1'b1, 1'b1);
      test_random_stream(120, random_gain(0), random_gain(0), 1'b1, 1'b1);
      test_random_stream(200, random_gain(0), random_gain(0), 1'b0, 1'b1);
      test_random_stream(200, random_gain(0), random_gain(0), 1'b1, 1'b0);
      start <= 1'b0;
      while (expected_chroma.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0 && expected_chroma.size() == 0) begin
         $display("tb_chroma_color_temperature_shift: done, clean");
      end else begin
         $display("tb_chroma_color_temperature_shift: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/ccts_pkg.sv
sv/chroma_color_temperature_shift.sv
sim/tb_chroma_color_temperature_shift.sv
